FILE: src/sync_frame_encoder_unwrap_assert.svh
// Assertion macros for the sync frame encoder unwrap block.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef SYNC_FRAME_ENCODER_UNWRAP_ASSERT_SVH
`define SYNC_FRAME_ENCODER_UNWRAP_ASSERT_SVH
`ifndef SYNTHESIS
`define SFEU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sfeu assertion failed");
`define SFEU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sfeu assertion failed");
`else
`define SFEU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SFEU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/sfeu_pkg.sv
// Shared types and constants for the sync frame encoder unwrap block.
// No dependencies.
package sfeu_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned DELTA_W    = 15;
  localparam int unsigned READING_W  = 16;
  localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
  localparam logic [2:0]  LAST_IDX   = 3'd4;
  localparam logic [15:0] READING_OFS = 16'h8000;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic            sum_ok;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: src/sfeu_parser.sv
// Front end: sync detection, byte collection and checksum check.
// Depends on sfeu_pkg.
module sfeu_parser import sfeu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output frame_t     frame_o
);

  logic            prev_sync_q, prev_sync_d;
  logic            in_frame_q, in_frame_d;
  logic [2:0]      idx_q, idx_d;
  logic [3:0][7:0] bytes_q, bytes_d;
  logic [7:0]      sum;
  logic            is_sync;

  assign is_sync = (rx_byte_i == SYNC_BYTE);
  assign sum     = bytes_q[0] + bytes_q[1] + bytes_q[2] + bytes_q[3];

  always_comb begin
    prev_sync_d = prev_sync_q;
    in_frame_d  = in_frame_q;
    idx_d       = idx_q;
    bytes_d     = bytes_q;
    push_o      = 1'b0;
    if (accept_i) begin
      if (is_sync && prev_sync_q) begin
        in_frame_d = 1'b1;
        idx_d      = '0;
      end else begin
        prev_sync_d = is_sync;
        if (in_frame_q) begin
          if (idx_q < LAST_IDX) begin
            bytes_d[idx_q[1:0]] = rx_byte_i;
            idx_d               = idx_q + 3'd1;
          end else begin
            push_o      = 1'b1;
            prev_sync_d = 1'b0;
            in_frame_d  = 1'b0;
            idx_d       = '0;
          end
        end
      end
    end
  end

  assign frame_o.data   = bytes_q;
  assign frame_o.sum_ok = (sum == rx_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sync_q <= 1'b0;
      in_frame_q  <= 1'b0;
      idx_q       <= '0;
    end else begin
      prev_sync_q <= prev_sync_d;
      in_frame_q  <= in_frame_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

endmodule

FILE: src/sfeu_fifo.sv
// Two-entry frame queue between parser and unwrap stage.
// Depends on sfeu_pkg.
module sfeu_fifo import sfeu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_t     wdata_i,
  input  logic       pop_i,
  output frame_t     rdata_o,
  output fifo_stat_t stat_o
);

  frame_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign rdata_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

FILE: src/sfeu_unwrap.sv
// Back end: encoder readings, wrapped deltas, accumulators, output register.
// Depends on sfeu_pkg.
module sfeu_unwrap import sfeu_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  frame_t                    frame_i,
  input  fifo_stat_t                stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      frame_ok_o,
  output logic signed [31:0]        position_a_o,
  output logic signed [31:0]        position_b_o,
  output logic signed [DELTA_W-1:0] delta_a_o,
  output logic signed [DELTA_W-1:0] delta_b_o
);

  logic                       first_q, first_d;
  logic [READING_W-1:0]       last_q [2];
  logic [READING_W-1:0]       last_d [2];
  logic signed [POS_W-1:0]    acc_q [2];
  logic signed [POS_W-1:0]    acc_d [2];
  logic signed [DELTA_W-1:0]  delta [2];
  logic [READING_W-1:0]       reading [2];
  logic [READING_W-1:0]       diff [2];
  logic                       valid_q, valid_d;
  logic                       ok_q;
  logic signed [DELTA_W-1:0]  dlt_q [2];

  assign pop_o = !stat_i.empty && (!valid_q || out_ready_i);

  always_comb begin
    first_d = first_q;
    for (int i = 0; i < 2; i++) begin
      reading[i] = READING_OFS - {frame_i.data[2*i], frame_i.data[2*i+1]};
      diff[i]    = reading[i] - last_q[i];
      delta[i]   = '0;
      last_d[i]  = last_q[i];
      acc_d[i]   = acc_q[i];
      if (pop_o && frame_i.sum_ok) begin
        last_d[i] = reading[i];
        if (!first_q) begin
          delta[i] = diff[i][DELTA_W-1:0];
          acc_d[i] = acc_q[i] + POS_W'(delta[i]);
        end
      end
    end
    if (pop_o && frame_i.sum_ok) first_d = 1'b0;
    valid_d = pop_o ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      valid_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        last_q[i] <= '0;
        acc_q[i]  <= '0;
      end
    end else begin
      first_q <= first_d;
      valid_q <= valid_d;
      for (int i = 0; i < 2; i++) begin
        last_q[i] <= last_d[i];
        acc_q[i]  <= acc_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ok_q     <= frame_i.sum_ok;
      dlt_q[0] <= delta[0];
      dlt_q[1] <= delta[1];
    end
  end

  assign out_valid_o  = valid_q;
  assign frame_ok_o   = ok_q;
  assign position_a_o = 32'(acc_q[0]);
  assign position_b_o = 32'(acc_q[1]);
  assign delta_a_o    = dlt_q[0];
  assign delta_b_o    = dlt_q[1];

endmodule

FILE: src/sync_frame_encoder_unwrap.sv
// Sync frame parser with encoder delta unwrap: one rx byte in, a result per frame.
// The checksum byte queues the frame; unwrap pops it and registers the result.
// Throughput: one byte per cycle; the two-entry frame queue lets the parser run
// while the output register is stalled, tready drops only when the queue is full.
// Reset: rst_ni asynchronous active low; parser idle, first frame pending,
// readings and positions zero, queue and output empty. Uses sfeu_pkg and submodules.
`include "sync_frame_encoder_unwrap_assert.svh"
module sync_frame_encoder_unwrap import sfeu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // [0] frame_ok, [32:1] position_a,
                                      // [64:33] position_b, [79:65] delta_a,
                                      // [94:80] delta_b, [95] zero
);

  logic                      accept, push, pop;
  frame_t                    wframe, rframe;
  fifo_stat_t                stat;
  logic                      frame_ok;
  logic signed [31:0]        position_a, position_b;
  logic signed [DELTA_W-1:0] delta_a, delta_b;

  assign s_axis_tready = !stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sfeu_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (s_axis_tdata),
    .push_o    (push),
    .frame_o   (wframe)
  );

  sfeu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wframe),
    .pop_i   (pop),
    .rdata_o (rframe),
    .stat_o  (stat)
  );

  sfeu_unwrap u_unwrap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (rframe),
    .stat_i       (stat),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .frame_ok_o   (frame_ok),
    .position_a_o (position_a),
    .position_b_o (position_b),
    .delta_a_o    (delta_a),
    .delta_b_o    (delta_b)
  );

  assign m_axis_tdata = {1'b0, delta_b, delta_a, position_b, position_a, frame_ok};

  `SFEU_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, stat.full, !push)
  `SFEU_ASSERT_IMP(a_err_zero_delta, clk_i, rst_ni, m_axis_tvalid && !frame_ok, ~|{delta_b, delta_a})
  `SFEU_ASSERT_NXT(a_push_reaches_queue, clk_i, rst_ni, push && !pop, !stat.empty)

endmodule
